>>> rtl/chs_pkg.sv
// shared types and constants for the chained hash set
`timescale 1ns / 1ps
package chs_pkg;

  localparam int CMD_W   = 2;
  localparam int EPOCH_W = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = 16'hFFFF;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 16'd1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_BKT,
    S_ENT,
    S_FIN,
    S_WIPE
  } state_t;

endpackage

>>> rtl/chs_req_if.sv
// command channel: operation code and key
`timescale 1ns / 1ps
interface chs_req_if #(
  parameter int KEY_BITS = 29
) ();
  import chs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink (input valid, input command, input key, output ready);
endinterface

>>> rtl/chs_rsp_if.sv
// result channel: found flag and status
`timescale 1ns / 1ps
interface chs_rsp_if ();
  logic valid;
  logic ready;
  logic found;
  logic status;

  modport source (output valid, output found, output status, input ready);
  modport sink (input valid, input found, input status, output ready);
endinterface

>>> rtl/chs_ram.sv
// simple dual-port memory with registered read
`timescale 1ns / 1ps
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/chained_hash_set_unit.sv
// top level of the chained hash set: sequencer, bucket memory and entry memory
`timescale 1ns / 1ps
// Hash set of keys kept as chains per bucket (bucket = low key bits), with
// entries taken in order from a pool and a stamp per bucket so that a clear
// normally leaves the bucket memory alone. One item is processed at a time.
// Insert, lookup and delete read the bucket memory after acceptance, then the
// visited chain entries one at a time on the single read port of the entry
// memory, and end in a finishing state that waits for a free output and writes
// the entry of an insert that adds a key. Lookup stops at the first live match,
// delete always walks the whole chain. A clear goes straight to the finishing
// state, but when the epoch counter is at its top value all 2^BUCKET_BITS
// bucket stamps are rewritten first, one per cycle. After reset the same pass
// runs over all 2^BUCKET_BITS buckets and no item is accepted meanwhile. A new
// item is accepted while the previous result still waits on the output.
module chained_hash_set_unit #(
  parameter int BUCKET_BITS = 10,
  parameter int POOL_DEPTH  = 1024,
  parameter int KEY_BITS    = 29
) (
  input logic       clk,
  input logic       rst,
  chs_req_if.sink   req,
  chs_rsp_if.source rsp
);
  import chs_pkg::*;

  localparam int NB     = 1 << BUCKET_BITS;
  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam int EIDX_W = $clog2(POOL_DEPTH);
  localparam int KX     = (KEY_BITS > BUCKET_BITS) ? KEY_BITS : BUCKET_BITS;
  localparam int BKT_W  = EPOCH_W + LINK_W;
  localparam int ENT_W  = 1 + LINK_W + KEY_BITS;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

  state_t state, state_next;

  logic [CMD_W-1:0]       cur_cmd;
  logic [KEY_BITS-1:0]    cur_key;
  logic [EPOCH_W-1:0]     epoch;
  logic [LINK_W-1:0]      alloc;
  logic [LINK_W-1:0]      head;
  logic [LINK_W-1:0]      ptr;
  logic [LINK_W-1:0]      steps;
  logic                   hit;
  logic [BUCKET_BITS-1:0] sweep_addr;
  logic                   rsp_valid;
  logic                   rsp_found;
  logic                   rsp_status;

  logic                   bkt_we;
  logic [BUCKET_BITS-1:0] bkt_waddr;
  logic [BKT_W-1:0]       bkt_wdata;
  logic [BUCKET_BITS-1:0] bkt_raddr;
  logic [BKT_W-1:0]       bkt_rdata;
  logic                   ent_we;
  logic [EIDX_W-1:0]      ent_waddr;
  logic [ENT_W-1:0]       ent_wdata;
  logic [EIDX_W-1:0]      ent_raddr;
  logic [ENT_W-1:0]       ent_rdata;

  logic [KEY_BITS-1:0]    in_key;
  logic [KX-1:0]          in_key_x;
  logic [KX-1:0]          cur_key_x;
  logic [BUCKET_BITS-1:0] cur_bkt;
  logic [EPOCH_W-1:0]     bkt_stamp;
  logic [LINK_W-1:0]      bkt_head;
  logic                   bkt_live;
  logic [LINK_W-1:0]      head_eff;
  logic                   ent_dead;
  logic [LINK_W-1:0]      ent_link;
  logic [KEY_BITS-1:0]    ent_key;
  logic                   ent_match;
  logic [LINK_W-1:0]      steps_inc;
  logic                   walk_on;
  logic                   ins_new;
  logic                   out_free;
  logic                   sweep_last;

  chs_ram #(.WIDTH(BKT_W), .DEPTH(NB)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  chs_ram #(.WIDTH(ENT_W), .DEPTH(POOL_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign in_key    = KEY_BITS'(req.key);
  assign in_key_x  = KX'(in_key);
  assign cur_key_x = KX'(cur_key);
  assign cur_bkt   = cur_key_x[BUCKET_BITS-1:0];

  assign bkt_stamp = bkt_rdata[BKT_W-1 -: EPOCH_W];
  assign bkt_head  = bkt_rdata[LINK_W-1:0];
  assign bkt_live  = bkt_stamp >= epoch;
  assign head_eff  = bkt_live ? bkt_head : NIL;

  assign ent_dead  = ent_rdata[ENT_W-1];
  assign ent_link  = ent_rdata[KEY_BITS +: LINK_W];
  assign ent_key   = ent_rdata[KEY_BITS-1:0];
  assign ent_match = !ent_dead && (ent_key == cur_key);

  assign steps_inc  = steps + 1'b1;
  assign walk_on    = !(ent_match && (cur_cmd != CMD_DELETE)) &&
                      (ent_link < NIL) && (steps_inc < NIL);
  assign ins_new    = (cur_cmd == CMD_INSERT) && !hit && (alloc < NIL);
  assign out_free   = !rsp_valid || rsp.ready;
  assign sweep_last = sweep_addr == '1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          if (req.command == CMD_CLEAR) begin
            state_next = (epoch >= EPOCH_MAX) ? S_WIPE : S_FIN;
          end else begin
            state_next = S_BKT;
          end
        end
      end
      S_BKT: begin
        state_next = (head_eff < NIL) ? S_ENT : S_FIN;
      end
      S_ENT: begin
        if (!walk_on) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      S_WIPE: begin
        if (sweep_last) state_next = S_FIN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    req.ready = state == S_IDLE;
    bkt_raddr = in_key_x[BUCKET_BITS-1:0];
    bkt_we    = 1'b0;
    bkt_waddr = cur_bkt;
    bkt_wdata = {epoch, NIL};
    ent_raddr = ptr[EIDX_W-1:0];
    ent_we    = 1'b0;
    ent_waddr = ptr[EIDX_W-1:0];
    ent_wdata = {1'b1, ent_link, ent_key};
    case (state)
      S_INIT, S_WIPE: begin
        bkt_we    = 1'b1;
        bkt_waddr = sweep_addr;
        bkt_wdata = '0;
      end
      S_BKT: begin
        bkt_we    = !bkt_live && (cur_cmd != CMD_LOOKUP);
        ent_raddr = head_eff[EIDX_W-1:0];
      end
      S_ENT: begin
        ent_raddr = ent_link[EIDX_W-1:0];
        ent_we    = ent_match && (cur_cmd == CMD_DELETE);
      end
      S_FIN: begin
        bkt_we    = out_free && ins_new;
        bkt_wdata = {epoch, alloc};
        ent_we    = out_free && ins_new;
        ent_waddr = alloc[EIDX_W-1:0];
        ent_wdata = {1'b0, head, cur_key};
      end
      default: begin
        bkt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      epoch      <= EPOCH_FIRST;
      alloc      <= '0;
      sweep_addr <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT || state == S_WIPE) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (state == S_IDLE && req.valid && req.command == CMD_CLEAR) begin
        alloc <= '0;
        epoch <= (epoch >= EPOCH_MAX) ? EPOCH_FIRST : epoch + 1'b1;
      end
      if (state == S_FIN && out_free && ins_new) begin
        alloc <= alloc + 1'b1;
      end
      if (state == S_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cur_cmd <= req.command;
          cur_key <= in_key;
          hit     <= 1'b0;
        end
      end
      S_BKT: begin
        head  <= head_eff;
        ptr   <= head_eff;
        steps <= '0;
      end
      S_ENT: begin
        if (ent_match) hit <= 1'b1;
        ptr   <= ent_link;
        steps <= steps_inc;
      end
      S_FIN: begin
        if (out_free) begin
          rsp_found  <= hit && (cur_cmd == CMD_INSERT || cur_cmd == CMD_LOOKUP);
          rsp_status <= ((cur_cmd == CMD_INSERT) && !hit && (alloc >= NIL)) ?
                        STATUS_FULL : STATUS_DONE;
        end
      end
      default: begin
        hit <= hit;
      end
    endcase
  end

  assign rsp.valid  = rsp_valid;
  assign rsp.found  = rsp_found;
  assign rsp.status = rsp_status;

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0) else $error("epoch counter reached zero");

  a_alloc_range: assert property (@(posedge clk) disable iff (rst)
    alloc <= NIL) else $error("pool pointer past pool end");

  a_walk_ptr: assert property (@(posedge clk) disable iff (rst)
    state == S_ENT |-> ptr < NIL) else $error("chain walk on end link");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> rsp_valid) else $error("result not loaded");

  a_dual_write: assert property (@(posedge clk) disable iff (rst)
    (bkt_we && ent_we) |-> state == S_FIN) else $error("unexpected dual write");

endmodule

>>> test/testbench.sv
// self-checking testbench for the chained hash set unit
`timescale 1ns / 1ps
module testbench;
  import chs_pkg::*;

  localparam int KEY_W    = 29;
  localparam int BKT_W    = 10;
  localparam int POOL     = 1024;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic found;
    logic status;
  } set_answer_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    bit               fixed;
    logic             found;
    logic             status;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  chs_req_if #(.KEY_BITS(KEY_W)) req ();
  chs_rsp_if rsp ();

  chained_hash_set_unit #(
    .BUCKET_BITS(BKT_W),
    .POOL_DEPTH(POOL),
    .KEY_BITS(KEY_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  // shadow copy of the set
  logic [10:0]      head_of [1 << BKT_W];
  logic [15:0]      stamp_of [1 << BKT_W];
  logic [15:0]      cur_epoch;
  logic [KEY_W-1:0] pool_key [POOL];
  logic [10:0]      pool_next [POOL];
  bit               pool_dead [POOL];
  int               next_free;

  set_answer_t   pending_answers[$];
  directed_row_t directed_rows[$];
  set_answer_t   want;
  int            mismatch_count = 0;
  int            stall_cycles = 0;
  bit            calm_stretch = 1'b0;

  function automatic void refresh_bucket(input int b);
    if (stamp_of[b] < cur_epoch) begin
      stamp_of[b] = cur_epoch;
      head_of[b]  = 11'(POOL);
    end
  endfunction

  function automatic bit chain_hit(input int b, input logic [KEY_W-1:0] k, input bit kill);
    int p;
    int steps;
    bit hit;
    p = head_of[b];
    steps = 0;
    hit = 1'b0;
    while (p < POOL && steps < POOL && !(hit && !kill)) begin
      if (!pool_dead[p] && pool_key[p] == k) begin
        hit = 1'b1;
        if (kill) pool_dead[p] = 1'b1;
      end
      p = pool_next[p];
      steps++;
    end
    return hit;
  endfunction

  function automatic set_answer_t expected_answer(input logic [CMD_W-1:0] cmd,
                                                  input logic [KEY_W-1:0] k);
    set_answer_t a;
    int b;
    a.found = 1'b0;
    a.status = STATUS_DONE;
    b = int'(k[BKT_W-1:0]);
    case (cmd)
      CMD_INSERT: begin
        refresh_bucket(b);
        if (chain_hit(b, k, 1'b0)) begin
          a.found = 1'b1;
        end else if (next_free >= POOL) begin
          a.status = STATUS_FULL;
        end else begin
          pool_key[next_free]  = k;
          pool_dead[next_free] = 1'b0;
          pool_next[next_free] = head_of[b];
          head_of[b] = 11'(next_free);
          next_free++;
        end
      end
      CMD_LOOKUP: begin
        if (stamp_of[b] >= cur_epoch && chain_hit(b, k, 1'b0)) a.found = 1'b1;
      end
      CMD_DELETE: begin
        refresh_bucket(b);
        void'(chain_hit(b, k, 1'b1));
      end
      CMD_CLEAR: begin
        if (cur_epoch >= EPOCH_MAX) begin
          foreach (stamp_of[j]) stamp_of[j] = '0;
          cur_epoch = EPOCH_FIRST;
        end else begin
          cur_epoch = cur_epoch + 1'b1;
        end
        next_free = 0;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                                  input bit fixed = 1'b0, input logic found = 1'b0,
                                  input logic status = STATUS_DONE);
    directed_row_t r;
    r.cmd = cmd;
    r.key = k;
    r.fixed = fixed;
    r.found = found;
    r.status = status;
    directed_rows = {directed_rows, r};
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                           input bit fixed = 1'b0, input logic fixed_found = 1'b0,
                           input logic fixed_status = STATUS_DONE);
    set_answer_t got;
    while (!calm_stretch && $urandom_range(0, 99) < 8) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.key     <= k;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    got = expected_answer(cmd, k);
    if (fixed) begin
      got.found = fixed_found;
      got.status = fixed_status;
    end
    pending_answers = {pending_answers, got};
    @(negedge clk);
  endtask

  task automatic random_ops(input int count);
    int n;
    int pick;
    logic [KEY_W-1:0] k;
    logic [18:0] upper;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        k = KEY_W'($urandom());
      end else begin
        case ($urandom_range(0, 3))
          0: upper = '0;
          1: upper = '1;
          2: upper = 19'h2AAAA;
          default: upper = 19'h55555;
        endcase
        k = {upper, 10'($urandom_range(0, 15) * 67)};
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) send_item(CMD_CLEAR, k);
      else if (pick < 45) send_item(CMD_INSERT, k);
      else if (pick < 75) send_item(CMD_LOOKUP, k);
      else send_item(CMD_DELETE, k);
    end
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= calm_stretch || ($urandom_range(0, 99) >= 8);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with nothing expected, found %b status %b",
                 $realtime, rsp.found, rsp.status);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp.found !== want.found) begin
          $display("%0t: found expected %b got %b", $realtime, want.found, rsp.found);
          mismatch_count++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %b got %b", $realtime, want.status, rsp.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0] kmax;

    rst = 1'b1;
    req.valid = 1'b0;
    req.command = CMD_LOOKUP;
    req.key = '0;
    foreach (stamp_of[j]) begin
      stamp_of[j] = '0;
      head_of[j] = '0;
    end
    foreach (pool_key[j]) begin
      pool_key[j] = '0;
      pool_next[j] = '0;
      pool_dead[j] = 1'b0;
    end
    cur_epoch = EPOCH_FIRST;
    next_free = 0;
    kmax = '1;

    add_row(CMD_LOOKUP, '0, 1'b1, 1'b0);
    add_row(CMD_INSERT, '0, 1'b1, 1'b0);
    add_row(CMD_INSERT, '0, 1'b1, 1'b1);
    add_row(CMD_LOOKUP, '0, 1'b1, 1'b1);
    add_row(CMD_INSERT, kmax, 1'b1, 1'b0);
    add_row(CMD_LOOKUP, kmax, 1'b1, 1'b1);
    add_row(CMD_INSERT, 29'h400, 1'b1, 1'b0);
    add_row(CMD_INSERT, 29'h800, 1'b1, 1'b0);
    add_row(CMD_LOOKUP, 29'h400, 1'b1, 1'b1);
    add_row(CMD_DELETE, '0, 1'b1, 1'b0);
    add_row(CMD_LOOKUP, '0, 1'b1, 1'b0);
    add_row(CMD_LOOKUP, 29'h800, 1'b1, 1'b1);
    add_row(CMD_INSERT, '0, 1'b1, 1'b0);
    add_row(CMD_LOOKUP, '0, 1'b1, 1'b1);
    add_row(CMD_DELETE, 29'h400, 1'b1, 1'b0);
    add_row(CMD_DELETE, 29'h400, 1'b1, 1'b0);
    add_row(CMD_LOOKUP, 29'h400, 1'b1, 1'b0);
    add_row(CMD_INSERT, 29'h0AAAAAAA);
    add_row(CMD_LOOKUP, 29'h15555555);
    add_row(CMD_CLEAR, kmax, 1'b1, 1'b0);
    add_row(CMD_LOOKUP, kmax, 1'b1, 1'b0);
    add_row(CMD_DELETE, kmax, 1'b1, 1'b0);
    add_row(CMD_INSERT, kmax, 1'b1, 1'b0);
    add_row(CMD_LOOKUP, kmax, 1'b1, 1'b1);
    add_row(CMD_LOOKUP, '0, 1'b1, 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r])
      send_item(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].fixed,
                directed_rows[r].found, directed_rows[r].status);

    random_ops(300);

    // back to back with no idling on either side
    calm_stretch = 1'b1;
    random_ops(100);
    calm_stretch = 1'b0;

    send_item(CMD_CLEAR, '0);
    send_item(CMD_INSERT, {19'h12345, 10'd700});
    send_item(CMD_INSERT, {19'h7FFFF, 10'd700});
    send_item(CMD_LOOKUP, {19'h12345, 10'd700});
    send_item(CMD_DELETE, {19'h12345, 10'd700});
    send_item(CMD_INSERT, {19'h12345, 10'd700});
    send_item(CMD_LOOKUP, {19'h12345, 10'd700});
    random_ops(20);

    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
